/* hw/rtl/lcg48r_pkg.sv */
// Shared types, opcodes and constants of the bounded 48-bit LCG block.
`timescale 1ns / 1ps

package lcg48r_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_DRAW48 = 2'd0;
  localparam logic [1:0] OP_DRAW32 = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  // Generator constants: r = (LCG_MULT * s + LCG_INC) mod 2^48.
  localparam int unsigned MPLIER_W = 35;
  localparam logic [MPLIER_W-1:0] LCG_MULT = 35'd25214903917;
  localparam logic [47:0] LCG_INC = 48'd11;

  // A 48-bit draw with a nonzero bound below this value is scaled, not reduced.
  localparam logic [63:0] SMALL_BOUND = 64'h0000_0000_0001_0000;

  // Iteration counts of the sequencer steps.
  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_LCG   = 6'd35;
  localparam logic [CNT_W-1:0] CNT_SCL16 = 6'd16;
  localparam logic [CNT_W-1:0] CNT_SCL32 = 6'd32;
  localparam logic [CNT_W-1:0] CNT_DIV   = 6'd48;

  // Request to and answer from the shared adder.
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        cout;
  } alu_rsp_t;

endpackage

/* hw/rtl/lcg48r_alu.sv */
// Shared 64-bit adder and subtractor with carry out.
`timescale 1ns / 1ps

module lcg48r_alu (
  input  lcg48r_pkg::alu_req_t req,
  output lcg48r_pkg::alu_rsp_t rsp
);

  logic [63:0] b_op;
  logic [64:0] total;

  // Subtraction is a + ~b + 1; a carry out then means a >= b.
  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {64'b0, req.sub};

  assign rsp.sum  = total[63:0];
  assign rsp.cout = total[64];

endmodule

/* hw/rtl/bounded_lcg48_random.sv */
// Top level of the bounded 48-bit LCG: handshakes, seed store and sequencer.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Payload
//  in_*      input      in_valid/in_stall  opcode, use_given_seed, given_seed, upper_bound
//  out_*     output     out_valid/out_stall value
//
//  A seed load or an unused opcode passes from transfer through res_r to the output register.
//  A draw runs the LCG multiply on the shared adder, then nothing more (no bound), a
//  scaling multiply (small 48-bit bound or 32-bit bound) or a restoring modulo, then S_OUT.
//  The single shared 64-bit adder does one add per cycle in each of these steps.
//  Reset is synchronous and active low; it clears the stored seed to zero.
//  A stalled result stays in the output register while the next item is taken.
//
module bounded_lcg48_random (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_use_given_seed,
  input  logic [47:0] in_given_seed,
  input  logic [63:0] in_upper_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_value
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LCG  = 3'd1;
  localparam logic [2:0] S_SCL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int unsigned MW = lcg48r_pkg::MPLIER_W;

  // Control registers.
  logic [2:0]  state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] seed_r, seed_nxt;

  // Working registers of the current item.
  logic [1:0]                  op_r, op_nxt;
  logic                        use_r, use_nxt;
  logic [63:0]                 bound_r, bound_nxt;
  logic [63:0]                 acc_r, acc_nxt;
  logic [63:0]                 mcand_r, mcand_nxt;
  logic [MW-1:0]               mplier_r, mplier_nxt;
  logic [lcg48r_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [47:0]                 rem_r, rem_nxt;
  logic [47:0]                 dvd_r, dvd_nxt;
  logic [47:0]                 res_r, res_nxt;
  logic [47:0]                 out_value_r, out_value_nxt;

  lcg48r_pkg::alu_req_t alu_req;
  lcg48r_pkg::alu_rsp_t alu_rsp;

  logic        in_xfer;
  logic        out_load;
  logic [63:0] mult_acc;
  logic [48:0] trial;
  logic [47:0] rem_step;
  logic [47:0] r_val;

  lcg48r_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Items are taken only while the sequencer is idle; the output register
  // decouples this from the result side.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // The adder either accumulates a shifted multiplicand or, during the
  // modulo, tries to subtract the bound from the shifted-in partial remainder.
  assign trial = {rem_r, dvd_r[47]};

  always_comb begin
    if (state_r == S_DIV) begin
      alu_req.a   = {15'b0, trial};
      alu_req.b   = bound_r;
      alu_req.sub = 1'b1;
    end else begin
      alu_req.a   = acc_r;
      alu_req.b   = mcand_r;
      alu_req.sub = 1'b0;
    end
  end

  // One shift-and-add step: add only when the current multiplier bit is set.
  assign mult_acc = mplier_r[0] ? alu_rsp.sum : acc_r;
  assign r_val    = mult_acc[47:0];
  assign rem_step = alu_rsp.cout ? alu_rsp.sum[47:0] : trial[47:0];

  always_comb begin
    state_nxt  = state_r;
    seed_nxt   = seed_r;
    op_nxt     = op_r;
    use_nxt    = use_r;
    bound_nxt  = bound_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    res_nxt    = res_r;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_opcode;
          use_nxt   = in_use_given_seed;
          bound_nxt = in_upper_bound;
          case (in_opcode)
            lcg48r_pkg::OP_DRAW48, lcg48r_pkg::OP_DRAW32: begin
              // Start the multiply with the increment already in the sum.
              acc_nxt    = {16'b0, lcg48r_pkg::LCG_INC};
              mcand_nxt  = {16'b0, (in_use_given_seed ? in_given_seed : seed_r)};
              mplier_nxt = lcg48r_pkg::LCG_MULT;
              cnt_nxt    = lcg48r_pkg::CNT_LCG;
              state_nxt  = S_LCG;
            end
            lcg48r_pkg::OP_LOAD: begin
              seed_nxt  = in_given_seed;
              res_nxt   = in_given_seed;
              state_nxt = S_OUT;
            end
            default: begin
              // The unused opcode leaves the seed alone and returns zero.
              res_nxt   = 48'b0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_LCG: begin
        acc_nxt    = mult_acc;
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MW-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == 1) begin
          // Only the low 48 bits of the sum matter: the product is mod 2^48.
          if (!use_r) begin
            seed_nxt = r_val;
          end
          if (op_r == lcg48r_pkg::OP_DRAW48) begin
            if (bound_r == 64'b0) begin
              res_nxt   = r_val;
              state_nxt = S_OUT;
            end else if (bound_r < lcg48r_pkg::SMALL_BOUND) begin
              acc_nxt    = 64'b0;
              mcand_nxt  = {16'b0, r_val};
              mplier_nxt = {{(MW-16){1'b0}}, bound_r[15:0]};
              cnt_nxt    = lcg48r_pkg::CNT_SCL16;
              state_nxt  = S_SCL;
            end else begin
              rem_nxt   = 48'b0;
              dvd_nxt   = r_val;
              cnt_nxt   = lcg48r_pkg::CNT_DIV;
              state_nxt = S_DIV;
            end
          end else begin
            if (bound_r[31:0] == 32'b0) begin
              res_nxt   = {16'b0, r_val[31:0]};
              state_nxt = S_OUT;
            end else begin
              acc_nxt    = 64'b0;
              mcand_nxt  = {32'b0, r_val[31:0]};
              mplier_nxt = {{(MW-32){1'b0}}, bound_r[31:0]};
              cnt_nxt    = lcg48r_pkg::CNT_SCL32;
              state_nxt  = S_SCL;
            end
          end
        end
      end

      S_SCL: begin
        acc_nxt    = mult_acc;
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[MW-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == 1) begin
          if (op_r == lcg48r_pkg::OP_DRAW48) begin
            res_nxt = {32'b0, mult_acc[63:48]};
          end else begin
            res_nxt = {16'b0, mult_acc[63:32]};
          end
          state_nxt = S_OUT;
        end
      end

      S_DIV: begin
        // Restoring modulo: one dividend bit per cycle, MSB first.
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[46:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 1) begin
          res_nxt   = rem_step;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // Wait here only while an older result is still stalled.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_value_nxt = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and the stored seed are reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= 48'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    use_r       <= use_nxt;
    bound_r     <= bound_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  // In the cycle after an item is taken, the block stalls its input.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while the previous item was just accepted");

  // The seed changes only at the end of the LCG step or on a seed load.
  a_seed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LCG && !(in_xfer && in_opcode == lcg48r_pkg::OP_LOAD))
    |=> $stable(seed_r))
    else $error("stored seed changed outside a draw or load");

  // The partial remainder never reaches the bound during the modulo.
  a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({16'b0, rem_r} < bound_r))
    else $error("partial remainder reached the bound");

  // A fresh result only appears after the sequencer has finished an item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised without a finished item");

endmodule

/* verif/tb_bounded_lcg48_random.sv */
// Self-checking testbench for the bounded 48-bit LCG block: directed and random draws.
`timescale 1ns / 1ps

module tb_bounded_lcg48_random;

  // Opcode 3 has no function. It leaves the seed alone and returns zero.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The slowest draw is the LCG multiply followed by the restoring modulo. The
  // drain wait at the end allows for well over one such draw.
  localparam int DRAIN_CYCLES = 200;
  // The receiver's single long hold-off. It is long enough for the block to
  // fill up and push back on its input.
  localparam int LONG_HOLD = 600;
  // The watchdog trips after this many cycles without any transfer. It covers
  // the long hold-off, the longest sender gap and a full draw with margin.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 930;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        use_given;
    logic [47:0] seed;
    logic [63:0] bound;
    logic        wait_drain;  // hold this item back until every result is in
  } lcg_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic        in_use_given_seed = 1'b0;
  logic [47:0] in_given_seed = '0;
  logic [63:0] in_upper_bound = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] out_value;

  bounded_lcg48_random DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_use_given_seed (in_use_given_seed),
    .in_given_seed     (in_given_seed),
    .in_upper_bound    (in_upper_bound),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value)
  );

  always #2 clk = ~clk;

  // Items waiting to be sent, and the values expected back in transfer order.
  lcg_item_t   pending_items[$];
  logic [47:0] expected_values[$];

  // The testbench's own copy of the stored seed. It advances in the order in
  // which items are accepted.
  logic [47:0] model_seed = '0;

  int items_accepted = 0;
  int results_seen = 0;
  int failures = 0;
  int op_count[4] = '{0, 0, 0, 0};

  // One LCG step: (multiplier * s + increment) mod 2^48. The 48-bit context
  // truncates the product, which is the modulo.
  function automatic logic [47:0] lcg_advance(input logic [47:0] s);
    logic [47:0] prod;
    prod = 48'(lcg48r_pkg::LCG_MULT) * s;
    return prod + lcg48r_pkg::LCG_INC;
  endfunction

  // Works out the value that the block should return for one accepted item.
  // It also updates the stored seed in the same way the block does.
  function automatic logic [47:0] expected_value(input lcg_item_t it);
    logic [47:0]  r;
    logic [63:0]  b32;
    logic [127:0] scaled;
    expected_value = '0;
    case (it.opcode)
      lcg48r_pkg::OP_DRAW48, lcg48r_pkg::OP_DRAW32: begin
        r = lcg_advance(it.use_given ? it.seed : model_seed);
        if (!it.use_given) model_seed = r;
        if (it.opcode == lcg48r_pkg::OP_DRAW48) begin
          if (it.bound == 64'd0) begin
            expected_value = r;
          end else if (it.bound < lcg48r_pkg::SMALL_BOUND) begin
            // A small bound scales the draw into [0, bound).
            scaled = 128'(it.bound) * 128'(r);
            expected_value = 48'(scaled >> 48);
          end else begin
            expected_value = 48'({16'd0, r} % it.bound);
          end
        end else begin
          // The 32-bit draw ignores the upper half of the bound.
          b32 = {32'd0, it.bound[31:0]};
          if (b32 == 64'd0) begin
            expected_value = {16'd0, r[31:0]};
          end else begin
            scaled = 128'(b32) * 128'(r[31:0]);
            expected_value = 48'(scaled >> 32);
          end
        end
      end
      lcg48r_pkg::OP_LOAD: begin
        model_seed = it.seed;
        expected_value = it.seed;
      end
      default: expected_value = '0;
    endcase
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void queue_item(input logic [1:0] op, input logic ug,
                                     input logic [47:0] seed, input logic [63:0] bound,
                                     input logic drain);
    lcg_item_t it;
    it.opcode = op;
    it.use_given = ug;
    it.seed = seed;
    it.bound = bound;
    it.wait_drain = drain;
    pending_items.push_back(it);
  endfunction

  // The bound is drawn from several classes, so that every branch of the
  // bounding logic is hit often: unbounded, scaled, reduced, and bounds that
  // are only nonzero in the half that the 32-bit draw ignores.
  function automatic logic [63:0] random_bound();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return 64'($urandom_range(1, 65535));
      2:       return {16'd0, rand48()} | lcg48r_pkg::SMALL_BOUND;
      3, 4:    return {$urandom, $urandom};
      5:       return {32'd0, $urandom};
      6:       return {$urandom, 32'd0};
      7:       return 64'($urandom_range(65536, 70000));
      8:       return {$urandom, 32'($urandom_range(1, 255))};
      default: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic void queue_random_item(input logic drain);
    int          pick;
    logic [1:0]  op;
    logic [47:0] seed;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = lcg48r_pkg::OP_DRAW48;
    else if (pick < 85) op = lcg48r_pkg::OP_DRAW32;
    else if (pick < 96) op = lcg48r_pkg::OP_LOAD;
    else op = OP_UNUSED;
    // Zero seeds show up now and then, both for loads and for given seeds.
    seed = ($urandom_range(0, 15) == 0) ? 48'd0 : rand48();
    queue_item(op, $urandom_range(0, 3) == 0, seed, random_bound(), drain);
  endfunction

  // Sender. It works in bursts of random length with random gaps between
  // them. A payload is held steady until its transfer completes. An item
  // that is marked for draining is held back until every result has come
  // back. The counters are read before this edge's updates, so the check
  // does not depend on the order in which processes run.
  int burst_left = 1;
  int gap_left = 0;
  lcg_item_t cur_item;

  always @(posedge clk) begin : drive_items
    logic took;
    took = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        expected_values.push_back(expected_value(cur_item));
        items_accepted <= items_accepted + 1;
        op_count[cur_item.opcode]++;
      end
      if (took || !in_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].wait_drain &&
                       items_accepted + took != results_seen)) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_item.opcode;
          in_use_given_seed <= cur_item.use_given;
          in_given_seed <= cur_item.seed;
          in_upper_bound <= cur_item.bound;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // Most gaps are short. Some are long enough to land in any
            // phase of a draw, and some bursts have no gap at all.
            gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                     : $urandom_range(0, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It switches at random between stall patterns: never stalling,
  // coin-flip stalls, a fixed 2-of-5 pattern and mostly stalled.
  // Once 300 results have arrived, it holds off for one long stretch. This
  // fills the block and makes it stall its input.
  int       stall_cycle = 0;
  int       stall_mode = 0;
  int       hold_left = 0;
  logic     long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 256 == 255) stall_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 1);
          2:       out_stall <= (stall_cycle % 5 < 2);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Checker. Each result transfer is compared with the oldest expected value.
  always @(posedge clk) begin : check_results
    logic [47:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_values.size() == 0) begin
        $error("value: expected none, actual %h", out_value);
        failures++;
      end else begin
        want = expected_values.pop_front();
        if (want !== out_value) begin
          $error("value: expected %h, actual %h", want, out_value);
          failures++;
        end
      end
    end
  end

  // Watchdog. It counts cycles in which neither channel completes a transfer.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("bounded_lcg48_random: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // The directed part comes first. The first draw starts from the reset
    // seed. It is followed by a zero seed load, the bound extremes of both
    // draw widths, a bound above any 48-bit value and a 32-bit draw whose
    // bound has only upper bits set. Given-seed draws come next, with a
    // stored draw after them to show the stored seed did not move. Load
    // ignores use_given_seed and the bound, and the unused opcode is sent twice.
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_LOAD,   1'b0, 48'd0, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd1, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd65535, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd65536, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'h0001_0000_0000_0000, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b0, 48'd0, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b0, 48'd0, 64'd1, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b0, 48'd0, 64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b0, 48'd0, 64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_item(lcg48r_pkg::OP_LOAD,   1'b0, 48'hFFFF_FFFF_FFFF, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b1, 48'hFFFF_FFFF_FFFF, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b1, 48'd0, 64'd12345, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b1, 48'hFFFF_FFFF_FFFF, 64'd7, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'h1234_5678_9ABC, 64'd0, 1'b0);
    queue_item(OP_UNUSED, 1'b0, rand48(), {$urandom, $urandom}, 1'b0);
    queue_item(lcg48r_pkg::OP_LOAD,   1'b1, 48'h8000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd100000, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW32, 1'b0, 48'd0, 64'h0000_0000_8000_0000, 1'b0);
    queue_item(OP_UNUSED, 1'b1, 48'hFFFF_FFFF_FFFF, 64'd0, 1'b0);
    queue_item(lcg48r_pkg::OP_DRAW48, 1'b0, 48'd0, 64'd65535, 1'b0);

    // The random part. The sender pauses for a full drain at its start and
    // again halfway through.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_random_item(i == 0 || i == RANDOM_ITEMS / 2);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until everything is sent and answered, then let the block settle.
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || items_accepted != results_seen);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_values.size() != 0) begin
      $error("value: %0d expected results never arrived", expected_values.size());
      failures++;
    end

    $display("Covered %0d items: %0d 48-bit draws, %0d 32-bit draws, %0d seed loads, %0d unused.",
             items_accepted, op_count[lcg48r_pkg::OP_DRAW48],
             op_count[lcg48r_pkg::OP_DRAW32], op_count[lcg48r_pkg::OP_LOAD],
             op_count[OP_UNUSED]);
    $display("Checked %0d results under bursty input, mixed output stalls and one long hold-off.",
             results_seen);
    if (failures == 0) begin
      $display("bounded_lcg48_random: match");
    end else begin
      $display("bounded_lcg48_random: mismatch");
    end
    $finish;
  end

endmodule
